>>> sv/pexp_pkg.sv
// Package for the prefix expression evaluator: character codes, status codes,
// default parameters and small fixed-point helper functions.
// No dependencies; used by prefix_expression_evaluator_top.
package pexp_pkg;

	localparam int WORD_W          = 64;
	localparam int STACK_DEPTH_DEF = 128;
	localparam int FRAC_BITS_DEF   = 24;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK    = 3'd0;
	localparam status_t ST_UNDER = 3'd1;
	localparam status_t ST_OVER  = 3'd2;
	localparam status_t ST_DIVZ  = 3'd3;
	localparam status_t ST_SAT   = 3'd4;

	// Keep the first error of an expression.
	function automatic status_t note_err(input status_t cur, input status_t code);
		return (cur == ST_OK) ? code : cur;
	endfunction

	// Largest positive or most negative word.
	function automatic logic [WORD_W-1:0] sat_val(input logic neg);
		return neg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
	endfunction

	// Absolute value of a two's complement word.
	function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
		return v[WORD_W-1] ? (~v + {{(WORD_W-1){1'b0}}, 1'b1}) : v;
	endfunction

endpackage

>>> sv/pexp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the operand stack of the evaluator.
module pexp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/prefix_expression_evaluator_top.sv
// Prefix expression evaluator over a signed fixed-point operand stack in RAM.
// A digit or space is taken straight from the input; an add or subtract reads both
// operands and makes one pass through the shared adder, a multiply or divide 64 passes.
// A character with last set adds a stack top read and a result load.
// Reset (arst_n low) empties the stack, clears the error and drops any result word.
// Depends on pexp_pkg and pexp_ram.
module prefix_expression_evaluator_top #(
	parameter int STACK_DEPTH = pexp_pkg::STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = pexp_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [7:0]                    ch,
	input  logic                          last,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [pexp_pkg::WORD_W-1:0] value,
	output logic [2:0]                    status
);

	localparam int W      = pexp_pkg::WORD_W;
	localparam int IW     = $clog2(STACK_DEPTH);
	localparam int CW     = $clog2(STACK_DEPTH + 1);
	localparam int ITER_W = $clog2(W);
	localparam int AW     = W + 2;

	// The sequencer. Operators read both operands from the RAM one after
	// the other, then run through the shared adder: once for add and
	// subtract, 64 times for the shift-add multiply and the restoring divide.
	typedef enum logic [3:0] {
		S_IDLE,
		S_RDL,
		S_RDR,
		S_PREP,
		S_DCHK,
		S_ITER,
		S_FIN,
		S_DONE,
		S_RDTOP,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	state_t             state_q;
	op_t                op_q;
	op_t                op_dec;
	logic [CW-1:0]      cnt_q;
	pexp_pkg::status_t  err_q;
	logic               last_q;
	logic [ITER_W-1:0]  iter_q;
	logic               neg_q;
	logic [W-1:0]       a_q;
	logic [W-1:0]       b_q;
	logic [W-1:0]       hi_q;
	logic [W-1:0]       lo_q;
	logic [W-1:0]       res_q;
	logic               out_valid_q;
	logic [W-1:0]       value_q;
	pexp_pkg::status_t  status_q;

	logic [CW-1:0]      cnt_m1;
	logic [CW-1:0]      cnt_m2;
	logic               full;
	logic               is_digit;
	logic               is_arith;
	logic [W-1:0]       digit_val;

	// RAM port signals.
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [W-1:0]       ram_wdata;
	logic               ram_re;
	logic [IW-1:0]      ram_raddr;
	logic [W-1:0]       ram_rdata;

	// The shared adder/subtractor, two bits wider than a word so that a
	// borrow out of an unsigned compare shows in the top bit.
	logic [AW-1:0]      alu_a;
	logic [AW-1:0]      alu_b;
	logic               alu_sub;
	logic [AW-1:0]      alu_y;
	logic               alu_ge;

	logic [2*W-1:0]     prod_sh;
	logic [2*W-1:0]     num_sh;
	logic [W-1:0]       fin_mag;
	logic               fin_big;
	logic               fin_over;
	logic [W-1:0]       addsub_r;
	logic               addsub_ovf;

	assign cnt_m1    = cnt_q - CW'(1);
	assign cnt_m2    = cnt_q - CW'(2);
	assign full      = (cnt_q >= CW'(STACK_DEPTH));
	assign is_digit  = (ch >= pexp_pkg::CH_ZERO) && (ch <= pexp_pkg::CH_NINE);
	assign is_arith  = (ch == pexp_pkg::CH_PLUS) || (ch == pexp_pkg::CH_MINUS) ||
	                   (ch == pexp_pkg::CH_STAR) || (ch == pexp_pkg::CH_SLASH);
	assign digit_val = W'(ch - pexp_pkg::CH_ZERO) << FRAC_BITS;

	always_comb begin
		unique case (ch)
			pexp_pkg::CH_PLUS:  op_dec = OP_ADD;
			pexp_pkg::CH_MINUS: op_dec = OP_SUB;
			pexp_pkg::CH_STAR:  op_dec = OP_MUL;
			default:            op_dec = OP_DIV;
		endcase
	end

	// The full product sits in hi_q:lo_q after the multiply passes; the
	// fixed-point result is its middle word, and any bit above it overflows.
	assign prod_sh  = {hi_q, lo_q} >> FRAC_BITS;
	assign num_sh   = {{W{1'b0}}, pexp_pkg::mag(a_q)} << FRAC_BITS;
	assign fin_mag  = (op_q == OP_MUL) ? prod_sh[W-1:0] : lo_q;
	assign fin_big  = (op_q == OP_MUL) ? (|prod_sh[2*W-1:W]) : 1'b0;
	assign fin_over = neg_q ? (fin_mag[W-1] && (|fin_mag[W-2:0])) : fin_mag[W-1];

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_PREP: begin
				alu_a   = {{2{a_q[W-1]}}, a_q};
				alu_b   = {{2{b_q[W-1]}}, b_q};
				alu_sub = (op_q == OP_SUB);
			end
			S_DCHK: begin
				alu_a   = {2'b00, hi_q};
				alu_b   = {2'b00, b_q};
				alu_sub = 1'b1;
			end
			S_ITER: begin
				if (op_q == OP_MUL) begin
					alu_a = {2'b00, hi_q};
					alu_b = lo_q[0] ? {2'b00, a_q} : '0;
				end else begin
					// Restoring divide: shift the next dividend bit into the remainder.
					alu_a   = {1'b0, hi_q, lo_q[W-1]};
					alu_b   = {2'b00, b_q};
					alu_sub = 1'b1;
				end
			end
			S_FIN: begin
				alu_b   = {2'b00, fin_mag};
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = '0;
			end
		endcase
	end

	assign alu_y  = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);
	assign alu_ge = ~alu_y[AW-1];

	assign addsub_r   = alu_y[W-1:0];
	assign addsub_ovf = (op_q == OP_SUB) ?
	                    ((a_q[W-1] != b_q[W-1]) && (addsub_r[W-1] != a_q[W-1])) :
	                    ((a_q[W-1] == b_q[W-1]) && (addsub_r[W-1] != a_q[W-1]));

	// Stack RAM control: digits push straight from the input, results push
	// from res_q; reads always fetch the top or the entry under it.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[IW-1:0];
		ram_wdata = (state_q == S_IDLE) ? digit_val : res_q;
		ram_re    = 1'b0;
		ram_raddr = cnt_m1[IW-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_we = item_valid && is_digit && !full;
				ram_re = item_valid && is_arith && (cnt_q >= CW'(2));
			end
			S_RDL: begin
				ram_re    = 1'b1;
				ram_raddr = cnt_m2[IW-1:0];
			end
			S_DONE: begin
				ram_we = !full;
			end
			S_RDTOP: begin
				ram_re = (cnt_q != '0);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	pexp_ram #(
		.WIDTH (W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			err_q       <= pexp_pkg::ST_OK;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// In S_EMIT a taken word is replaced by the next one below.
			if (out_valid_q && result_ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						last_q <= last;
						op_q   <= op_dec;
						if (is_digit) begin
							if (full) begin
								err_q <= pexp_pkg::note_err(err_q, pexp_pkg::ST_OVER);
							end else begin
								cnt_q <= cnt_q + CW'(1);
							end
							state_q <= last ? S_RDTOP : S_IDLE;
						end else if (ch == pexp_pkg::CH_SPACE) begin
							state_q <= last ? S_RDTOP : S_IDLE;
						end else if (cnt_q < CW'(2)) begin
							err_q   <= pexp_pkg::note_err(err_q, pexp_pkg::ST_UNDER);
							cnt_q   <= '0;
							state_q <= last ? S_RDTOP : S_IDLE;
						end else if (is_arith) begin
							state_q <= S_RDL;
						end else begin
							// Unknown character: drop two operands, push nothing.
							cnt_q   <= cnt_m2;
							state_q <= last ? S_RDTOP : S_IDLE;
						end
					end
				end
				S_RDL: begin
					a_q     <= ram_rdata;
					state_q <= S_RDR;
				end
				S_RDR: begin
					b_q     <= ram_rdata;
					cnt_q   <= cnt_m2;
					state_q <= S_PREP;
				end
				S_PREP: begin
					unique case (op_q)
						OP_ADD, OP_SUB: begin
							if (addsub_ovf) begin
								res_q <= pexp_pkg::sat_val(a_q[W-1]);
								err_q <= pexp_pkg::note_err(err_q, pexp_pkg::ST_SAT);
							end else begin
								res_q <= addsub_r;
							end
							state_q <= S_DONE;
						end
						OP_MUL: begin
							a_q     <= pexp_pkg::mag(a_q);
							lo_q    <= pexp_pkg::mag(b_q);
							hi_q    <= '0;
							neg_q   <= a_q[W-1] ^ b_q[W-1];
							iter_q  <= '0;
							state_q <= S_ITER;
						end
						OP_DIV: begin
							if (b_q == '0) begin
								res_q   <= pexp_pkg::sat_val(a_q[W-1]);
								err_q   <= pexp_pkg::note_err(err_q, pexp_pkg::ST_DIVZ);
								state_q <= S_DONE;
							end else begin
								b_q     <= pexp_pkg::mag(b_q);
								hi_q    <= num_sh[2*W-1:W];
								lo_q    <= num_sh[W-1:0];
								neg_q   <= a_q[W-1] ^ b_q[W-1];
								state_q <= S_DCHK;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_DCHK: begin
					// A dividend high word at or above the divisor gives a
					// quotient wider than one word.
					if (alu_ge) begin
						res_q   <= pexp_pkg::sat_val(neg_q);
						err_q   <= pexp_pkg::note_err(err_q, pexp_pkg::ST_SAT);
						state_q <= S_DONE;
					end else begin
						iter_q  <= '0;
						state_q <= S_ITER;
					end
				end
				S_ITER: begin
					if (op_q == OP_MUL) begin
						hi_q <= alu_y[W:1];
						lo_q <= {alu_y[0], lo_q[W-1:1]};
					end else begin
						hi_q <= alu_ge ? alu_y[W-1:0] : {hi_q[W-2:0], lo_q[W-1]};
						lo_q <= {lo_q[W-2:0], alu_ge};
					end
					iter_q <= iter_q + ITER_W'(1);
					if (iter_q == ITER_W'(W - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_big || fin_over) begin
						res_q <= pexp_pkg::sat_val(neg_q);
						err_q <= pexp_pkg::note_err(err_q, pexp_pkg::ST_SAT);
					end else begin
						res_q <= neg_q ? alu_y[W-1:0] : fin_mag;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (full) begin
						err_q <= pexp_pkg::note_err(err_q, pexp_pkg::ST_OVER);
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
					state_q <= last_q ? S_RDTOP : S_IDLE;
				end
				S_RDTOP: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// The result word waits here only while the previous one
					// has not been taken.
					if (!out_valid_q || result_ready) begin
						if (cnt_q == '0) begin
							value_q  <= '0;
							status_q <= pexp_pkg::note_err(err_q, pexp_pkg::ST_UNDER);
						end else begin
							value_q  <= ram_rdata;
							status_q <= err_q;
						end
						out_valid_q <= 1'b1;
						cnt_q       <= '0;
						err_q       <= pexp_pkg::ST_OK;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign value        = value_q;
	assign status       = status_q;

	// The stack count never runs past the RAM.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// A push only lands below the top of the RAM.
	a_push_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cnt_q < CW'(STACK_DEPTH)))
		else $error("stack write while full");

	// Loading a result word starts the next expression clean.
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (cnt_q == '0) && (err_q == pexp_pkg::ST_OK))
		else $error("stack or error not cleared after result");

	// A held result word is never overwritten before it is taken.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_ready) |=> $stable(value_q) && $stable(status_q))
		else $error("result word changed while stalled");

	// A divide whose quotient fits in one word goes on to its passes with the count at zero.
	a_div_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DCHK && !alu_ge) |=> (state_q == S_ITER) && (iter_q == '0))
		else $error("divide iteration started out of order");

endmodule

>>> verif/prefix_expression_evaluator_check.sv
// Checker for the prefix expression evaluator: watches the character and result
// channels, predicts each result word and compares it with what the block delivers.
// Depends on pexp_pkg for widths, character codes and status codes.
module prefix_expression_evaluator_check #(
	parameter int STACK_DEPTH = pexp_pkg::STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = pexp_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	input  logic                               item_ready,
	input  logic [7:0]                         ch,
	input  logic                               last,
	input  logic                               result_valid,
	input  logic                               result_ready,
	input  logic signed [pexp_pkg::WORD_W-1:0] value,
	input  logic [2:0]                         status,
	output int                                 mismatches,
	output int                                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_W = pexp_pkg::WORD_W;

	localparam logic [WORD_W-1:0] MAX_POS = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] MIN_NEG = {1'b1, {(WORD_W-1){1'b0}}};

	typedef struct packed {
		logic [WORD_W-1:0]  val;
		pexp_pkg::status_t  st;
	} answer_t;

	answer_t           answers_due[$];
	logic [WORD_W-1:0] operand_mem[STACK_DEPTH];
	int                sp;
	pexp_pkg::status_t first_err;

	function automatic void record(input pexp_pkg::status_t code);
		if (first_err == pexp_pkg::ST_OK) begin
			first_err = code;
		end
	endfunction

	function automatic logic [WORD_W-1:0] clip(input logic neg);
		record(pexp_pkg::ST_SAT);
		return neg ? MIN_NEG : MAX_POS;
	endfunction

	function automatic logic [WORD_W-1:0] abs_of(input logic [WORD_W-1:0] v);
		return v[WORD_W-1] ? -v : v;
	endfunction

	// Turns a truncated magnitude back into a signed word, clipping out-of-range results.
	function automatic logic [WORD_W-1:0] signed_from(input logic [WORD_W-1:0] m,
			input logic neg, input logic wide);
		if (wide || m > (neg ? MIN_NEG : MAX_POS)) begin
			return clip(neg);
		end
		return neg ? -m : m;
	endfunction

	function automatic logic [WORD_W-1:0] fx_sum(input logic [WORD_W-1:0] a, b,
			input logic subtract);
		logic [WORD_W-1:0] r;
		logic              risky;
		r     = subtract ? a - b : a + b;
		risky = subtract ? (a[WORD_W-1] != b[WORD_W-1]) : (a[WORD_W-1] == b[WORD_W-1]);
		if (risky && r[WORD_W-1] != a[WORD_W-1]) begin
			return clip(a[WORD_W-1]);
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] fx_product(input logic [WORD_W-1:0] a, b);
		logic [2*WORD_W-1:0] prod;
		prod = ({{WORD_W{1'b0}}, abs_of(a)} * {{WORD_W{1'b0}}, abs_of(b)}) >> FRAC_BITS;
		return signed_from(prod[WORD_W-1:0], a[WORD_W-1] != b[WORD_W-1],
			prod[2*WORD_W-1:WORD_W] != '0);
	endfunction

	function automatic logic [WORD_W-1:0] fx_quotient(input logic [WORD_W-1:0] a, b);
		logic [2*WORD_W-1:0] num, quo;
		if (b == '0) begin
			record(pexp_pkg::ST_DIVZ);
			return a[WORD_W-1] ? MIN_NEG : MAX_POS;
		end
		num = {{WORD_W{1'b0}}, abs_of(a)} << FRAC_BITS;
		quo = num / {{WORD_W{1'b0}}, abs_of(b)};
		return signed_from(quo[WORD_W-1:0], a[WORD_W-1] != b[WORD_W-1],
			quo[2*WORD_W-1:WORD_W] != '0);
	endfunction

	function automatic void push_word(input logic [WORD_W-1:0] w);
		if (sp >= STACK_DEPTH) begin
			record(pexp_pkg::ST_OVER);
		end else begin
			operand_mem[sp] = w;
			sp++;
		end
	endfunction

	// One accepted character; on the leftmost one the answer is queued and the stack cleared.
	function automatic void step_evaluator(input logic [7:0] c, input logic fin);
		logic [WORD_W-1:0] lhs, rhs;
		answer_t           ans;
		if (c >= pexp_pkg::CH_ZERO && c <= pexp_pkg::CH_NINE) begin
			push_word({{(WORD_W-8){1'b0}}, c - pexp_pkg::CH_ZERO} << FRAC_BITS);
		end else if (c != pexp_pkg::CH_SPACE) begin
			if (sp < 2) begin
				record(pexp_pkg::ST_UNDER);
				sp = 0;
			end else begin
				lhs = operand_mem[sp-1];
				rhs = operand_mem[sp-2];
				sp -= 2;
				case (c)
					pexp_pkg::CH_PLUS:  push_word(fx_sum(lhs, rhs, 1'b0));
					pexp_pkg::CH_MINUS: push_word(fx_sum(lhs, rhs, 1'b1));
					pexp_pkg::CH_STAR:  push_word(fx_product(lhs, rhs));
					pexp_pkg::CH_SLASH: push_word(fx_quotient(lhs, rhs));
					default:  ;
				endcase
			end
		end
		if (fin) begin
			if (sp == 0) begin
				record(pexp_pkg::ST_UNDER);
				ans.val = '0;
			end else begin
				ans.val = operand_mem[sp-1];
			end
			ans.st = first_err;
			answers_due.push_back(ans);
			sp        = 0;
			first_err = pexp_pkg::ST_OK;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			answers_due.delete();
			sp          = 0;
			first_err   = pexp_pkg::ST_OK;
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (item_valid && item_ready) begin
				step_evaluator(ch, last);
			end
			if (result_valid && result_ready) begin
				if (answers_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result word with none pending: value %h status %0d",
							$realtime, value, status);
					end
				end else begin
					want = answers_due.pop_front();
					if (value !== want.val || status !== want.st) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: expected value %h status %0d, got value %h status %0d",
								$realtime, want.val, want.st, value, status);
						end
					end
				end
			end
			outstanding = answers_due.size();
		end
	end

endmodule

>>> verif/prefix_expression_evaluator_top_test.sv
// Testbench top for the prefix expression evaluator: clock, reset, character stimulus
// and result back-pressure, with the checker instantiated beside the block.
// Depends on pexp_pkg, prefix_expression_evaluator_top and prefix_expression_evaluator_check.
module prefix_expression_evaluator_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	// The limit leaves a wide margin over the slowest legal run.
	localparam int CYCLE_LIMIT     = 1_000_000;
	// Quiet cycles after the last answer, longer than a divide plus the final read-out.
	localparam int DRAIN_CYCLES    = 200;
	localparam int ITEMS_PER_PHASE = 380;

	logic                               clk          = 1'b0;
	logic                               arst_n       = 1'b0;
	logic                               item_valid   = 1'b0;
	logic                               item_ready;
	logic [7:0]                         ch           = 8'h00;
	logic                               last         = 1'b0;
	logic                               result_valid;
	logic                               result_ready = 1'b0;
	logic signed [pexp_pkg::WORD_W-1:0] value;
	logic [2:0]                         status;

	int mismatches;
	int outstanding;
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int words_sent   = 0;
	int cycles       = 0;

	// Expression text in written (prefix) order; it is fed to the block back to front.
	logic [7:0] text_q[$];

	prefix_expression_evaluator_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.ch           (ch),
		.last         (last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.status       (status)
	);

	prefix_expression_evaluator_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.ch           (ch),
		.last         (last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.status       (status),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// The receiver stalls at random, one independent draw per cycle.
	always @(posedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
	end

	// Offers one word and waits for its acceptance. Valid is only lowered in a cycle
	// that is followed by a clock edge, so it is never dropped and raised in one step.
	task automatic send_word(input logic [7:0] c, input logic fin);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		ch         <= c;
		last       <= fin;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		words_sent++;
	endtask

	// Holds the sender off until every predicted answer has been delivered.
	task automatic settle();
		item_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (outstanding != 0);
	endtask

	// Sends the held text rightmost character first; the leftmost one carries last.
	task automatic feed_text();
		for (int i = text_q.size() - 1; i >= 0; i--) begin
			send_word(text_q[i], i == 0);
		end
	endtask

	task automatic feed_string(input string s);
		text_q.delete();
		foreach (s[i]) begin
			text_q.push_back(s[i]);
		end
		feed_text();
	endtask

	function automatic logic [7:0] op_char(input int unsigned k);
		case (k)
			0:       return pexp_pkg::CH_PLUS;
			1:       return pexp_pkg::CH_MINUS;
			2:       return pexp_pkg::CH_STAR;
			default: return pexp_pkg::CH_SLASH;
		endcase
	endfunction

	// Appends a token and, now and then, a separating space.
	function automatic void put_token(input logic [7:0] c);
		text_q.push_back(c);
		if ($urandom_range(0, 3) == 0) begin
			text_q.push_back(pexp_pkg::CH_SPACE);
		end
	endfunction

	// Random well-formed prefix expression. A few leaves are long products of large
	// digits, which can push past the integer range and exercise saturation downstream.
	function automatic void grow_tree(input int depth);
		int unsigned pick;
		int unsigned n;
		logic [7:0]  big;
		pick = $urandom_range(0, 99);
		if (depth == 0 || pick < 35) begin
			if (pick < 3) begin
				n   = $urandom_range(12, 15);
				big = 8'(pexp_pkg::CH_ZERO + $urandom_range(7, 9));
				repeat (n) put_token(pexp_pkg::CH_STAR);
				repeat (n + 1) put_token(big);
			end else begin
				put_token(8'(pexp_pkg::CH_ZERO + $urandom_range(0, 9)));
			end
		end else begin
			put_token(op_char($urandom_range(0, 3)));
			grow_tree(depth - 1);
			grow_tree(depth - 1);
		end
	endfunction

	// A run of digits near or past the stack limit, closed by up to five operators,
	// so stack overflow and the full-stack boundary can both be reached.
	function automatic void build_deep(input int unsigned n);
		text_q.delete();
		repeat ($urandom_range(0, 5)) text_q.push_back(op_char($urandom_range(0, 3)));
		repeat (n) text_q.push_back(8'(pexp_pkg::CH_ZERO + $urandom_range(0, 9)));
	endfunction

	initial begin
		int          target;
		int unsigned kind;
		int unsigned pos;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 21;
		recv_gap_pct = 75;

		// Directed opening: each operator, operand order, divide by zero, a negative
		// quotient, an operator short of operands, an empty stack at the end, and
		// the all-zero and all-one characters, which pop two values and push none.
		feed_string("-27");
		feed_string("*98");
		feed_string("/70");
		feed_string("/-057");
		feed_string("+1");
		feed_string(" ");
		text_q = '{8'hFF, pexp_pkg::CH_NINE, pexp_pkg::CH_NINE};
		feed_text();
		text_q = '{8'h35, 8'h00, 8'h31, 8'h32};
		feed_text();
		settle();

		// Three idling profiles: sender lightly and receiver heavily loaded, then the
		// reverse, then both channels running flat out.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 21;
					recv_gap_pct = 75;
				end
				1: begin
					send_gap_pct = 75;
					recv_gap_pct = 21;
				end
				default: begin
					send_gap_pct = 0;
					recv_gap_pct = 0;
				end
			endcase
			target = words_sent + ITEMS_PER_PHASE;
			if (phase == 0) begin
				build_deep(130);
				feed_text();
			end
			while (words_sent < target) begin
				kind = $urandom_range(0, 99);
				text_q.delete();
				if (kind < 72) begin
					// Mostly well-formed expressions, some with a leading space.
					if ($urandom_range(0, 9) == 0) begin
						text_q.push_back(pexp_pkg::CH_SPACE);
					end
					grow_tree($urandom_range(0, 4));
				end else if (kind < 84) begin
					// A well-formed expression with one character dropped or added.
					grow_tree($urandom_range(1, 3));
					pos = $urandom_range(0, text_q.size() - 1);
					case ($urandom_range(0, 2))
						0: begin
							if (text_q.size() > 1) begin
								text_q.delete(pos);
							end
						end
						1:       text_q.insert(pos, op_char($urandom_range(0, 3)));
						default: text_q.insert(pos, 8'($urandom_range(0, 255)));
					endcase
				end else if (kind < 97) begin
					// Noise: arbitrary bytes of any value.
					repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
				end else begin
					build_deep($urandom_range(124, 134));
				end
				feed_text();
				// Occasionally let the block run dry before the next expression.
				if ($urandom_range(0, 19) == 0) begin
					settle();
				end
			end
			settle();
		end

		// Every answer is in; give a stray word time to show before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/pexp_pkg.sv
sv/pexp_ram.sv
sv/prefix_expression_evaluator_top.sv
verif/prefix_expression_evaluator_check.sv
verif/prefix_expression_evaluator_top_test.sv
